// ===== src/sqgf_pkg.sv =====
// ----------------------------------------------------------------------------
// sqgf_pkg
// Shared types and constants for the single-qubit gate fuser.
// ----------------------------------------------------------------------------
package sqgf_pkg;

  localparam int QUBITS    = 64;
  localparam int QW        = 6;
  localparam int VAL_W     = 18;
  localparam int FRAC_BITS = 16;
  localparam int SQRT_STEPS = VAL_W;
  localparam int DIV_STEPS  = VAL_W;

  localparam logic [0:0] CMD_FUSE  = 1'b0;
  localparam logic [0:0] CMD_FLUSH = 1'b1;

  localparam logic [31:0] THR_RESET = 32'd43;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    val_t [3:0] im;
    val_t [3:0] re;
  } mat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ADD,
    ST_NORM,
    ST_CHECK,
    ST_SQRT,
    ST_DIV,
    ST_STORE,
    ST_IDNORM,
    ST_OUT
  } state_t;

endpackage

// ===== src/single_qubit_gate_fuser_top.sv =====
// ----------------------------------------------------------------------------
// single_qubit_gate_fuser_top
// Keeps one fused 2x2 complex gate per qubit in a synchronous memory and
// fuses, loads or flushes it per request.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  s_*     | in  | request: tuser = cmd, tdata = qubit, m0_re .. m3_im
//  m_*     | out | result: tuser = is_identity, entry_was_empty;
//          |     |         tdata = out_qubit, f0_re .. f3_im
//  APB     | in  | min_norm_threshold at byte address 0
//
// Load and flush requests pass through READ, IDNORM and OUT. A fuse into a
// valid entry runs the four product elements one after another through one
// complex multiply-add unit (MUL, ADD, NORM, CHECK, STORE), plus the
// bit-serial square root and the bit-serial divide (load, 18 quotient bits,
// sign and clamp) when an element needs renormalizing.
// Reset clears the valid bits and restores the threshold; the memory holds
// no reset. A result waiting in the output register holds the current
// request in flight and keeps the next one out.
// ----------------------------------------------------------------------------
module single_qubit_gate_fuser_top
  import sqgf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [151:0] s_tdata,   // qubit, m0_re, m0_im, m1_re, m1_im, m2_re,
                                  // m2_im, m3_re, m3_im, zero pad
  input  logic         s_tuser,   // cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [151:0] m_tdata,   // out_qubit, f0_re, f0_im, f1_re, f1_im,
                                  // f2_re, f2_im, f3_re, f3_im, zero pad
  output logic [1:0]   m_tuser,   // is_identity, entry_was_empty
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  state_t state, state_next;

  logic [31:0] thr;
  logic [QUBITS-1:0] used;
  mat_t mem [QUBITS];
  mat_t rd_data;

  logic [QW-1:0] qubit;
  logic          cmd;
  logic          was_empty;
  mat_t          nmat, smat, res;
  logic [1:0]    k;

  logic signed [35:0] p_arcr, p_aici, p_brdr, p_bidi;
  logic signed [35:0] p_arci, p_aicr, p_brdi, p_bidr;
  val_t cur_re, cur_im;
  logic [35:0] nrm;

  logic [35:0] rad;
  logic [19:0] srem;
  logic [17:0] root;
  logic [4:0]  cnt;

  logic [18:0] drem_re, drem_im;
  logic [17:0] dnum_re, dnum_im;
  logic [17:0] q_re, q_im;
  logic        ovf_re, ovf_im;

  logic [35:0] n1, n2;

  // ------------------------------------------------------------------
  // Configuration port
  // ------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? thr : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
      thr <= pwdata;
    end
  end

  // ------------------------------------------------------------------
  // Combinational helpers
  // ------------------------------------------------------------------
  logic        in_acc;
  mat_t        in_mat;
  val_t        a_re, a_im, b_re, b_im, c_re, c_im, d_re, d_im;
  logic signed [37:0] sum_re, sum_im, rnd_re, rnd_im;
  val_t        sat_re, sat_im;
  logic [35:0] tn;
  logic [36:0] nrm_plus;
  logic [21:0] sq_t, sq_trial;
  logic [17:0] mag_re, mag_im;
  logic [34:0] num_re, num_im;
  logic [19:0] d2_re, d2_im;
  val_t        fin_re, fin_im;
  logic [15:0] ta;
  val_t        lo, ta_s;
  logic        ident;
  logic        out_free;

  assign in_acc   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      in_mat.re[i] = s_tdata[6 + 36*i +: 18];
      in_mat.im[i] = s_tdata[24 + 36*i +: 18];
    end
  end

  // operand select for element k: row of N times column of S
  assign a_re = nmat.re[{k[1], 1'b0}];
  assign a_im = nmat.im[{k[1], 1'b0}];
  assign b_re = nmat.re[{k[1], 1'b1}];
  assign b_im = nmat.im[{k[1], 1'b1}];
  assign c_re = smat.re[{1'b0, k[0]}];
  assign c_im = smat.im[{1'b0, k[0]}];
  assign d_re = smat.re[{1'b1, k[0]}];
  assign d_im = smat.im[{1'b1, k[0]}];

  // sum, round half up, saturate
  assign sum_re = 38'(p_arcr) - 38'(p_aici) + 38'(p_brdr) - 38'(p_bidi);
  assign sum_im = 38'(p_arci) + 38'(p_aicr) + 38'(p_brdi) + 38'(p_bidr);
  assign rnd_re = (sum_re + 38'sd32768) >>> FRAC_BITS;
  assign rnd_im = (sum_im + 38'sd32768) >>> FRAC_BITS;
  assign sat_re = (rnd_re > 38'sd131071) ? 18'sd131071 :
                  (rnd_re < -38'sd131072) ? -18'sd131072 : rnd_re[17:0];
  assign sat_im = (rnd_im > 38'sd131071) ? 18'sd131071 :
                  (rnd_im < -38'sd131072) ? -18'sd131072 : rnd_im[17:0];

  assign tn       = {4'd0, thr};
  assign nrm_plus = {1'b0, nrm} + {1'b0, tn};

  // square root digit step
  assign sq_t     = {srem, rad[35:34]};
  assign sq_trial = {2'b00, root, 2'b01};

  // divider setup and step
  assign mag_re = cur_re[17] ? 18'(-{cur_re[17], cur_re}) : cur_re;
  assign mag_im = cur_im[17] ? 18'(-{cur_im[17], cur_im}) : cur_im;
  assign num_re = {1'b0, mag_re, 16'd0} + 35'(root >> 1);
  assign num_im = {1'b0, mag_im, 16'd0} + 35'(root >> 1);
  assign d2_re  = {drem_re, dnum_re[17]};
  assign d2_im  = {drem_im, dnum_im[17]};

  // clamp quotient and restore sign
  always_comb begin
    if (cur_re[17]) begin
      fin_re = (ovf_re || q_re > 18'd131072) ? -18'sd131072 : 18'(-q_re);
    end else begin
      fin_re = (ovf_re || q_re > 18'd131071) ? 18'sd131071 : q_re;
    end
    if (cur_im[17]) begin
      fin_im = (ovf_im || q_im > 18'd131072) ? -18'sd131072 : 18'(-q_im);
    end else begin
      fin_im = (ovf_im || q_im > 18'd131071) ? 18'sd131071 : q_im;
    end
  end

  // identity test on the reported matrix
  assign ta   = thr[31:16];
  assign ta_s = {2'b00, ta};
  assign lo   = 18'sd65536 - ta_s;
  assign ident = (n1 <= tn) && (n2 <= tn) &&
                 (res.re[0] >= lo) && (res.im[0] <= ta_s) && (res.im[0] >= -ta_s) &&
                 (res.re[3] >= lo) && (res.im[3] <= ta_s) && (res.im[3] >= -ta_s);

  // ------------------------------------------------------------------
  // Gate memory: one row per qubit, registered read
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data <= mem[s_tdata[QW-1:0]];
    end
    if (state == ST_OUT && out_free) begin
      mem[qubit] <= (cmd == CMD_FUSE) ? res : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (state == ST_OUT && out_free) begin
      used[qubit] <= (cmd == CMD_FUSE);
    end
  end

  // ------------------------------------------------------------------
  // State register and next state
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_acc) state_next = ST_READ;
      ST_READ: begin
        if (cmd == CMD_FUSE && !was_empty) state_next = ST_MUL;
        else state_next = ST_IDNORM;
      end
      ST_MUL:    state_next = ST_ADD;
      ST_ADD:    state_next = ST_NORM;
      ST_NORM:   state_next = ST_CHECK;
      ST_CHECK: begin
        if (nrm < tn) state_next = ST_STORE;
        else if (nrm_plus > 37'h1_0000_0000) state_next = ST_SQRT;
        else state_next = ST_STORE;
      end
      ST_SQRT: begin
        if (cnt == 5'(SQRT_STEPS - 1)) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (root == 18'd0 || cnt == 5'(DIV_STEPS + 1)) state_next = ST_STORE;
      end
      ST_STORE:  state_next = (k == 2'd3) ? ST_IDNORM : ST_MUL;
      ST_IDNORM: state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // Datapath
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          qubit     <= s_tdata[QW-1:0];
          cmd       <= s_tuser;
          nmat      <= in_mat;
          was_empty <= !used[s_tdata[QW-1:0]];
        end
      end
      ST_READ: begin
        smat <= rd_data;
        k    <= 2'd0;
        if (cmd == CMD_FUSE) begin
          res <= was_empty ? nmat : '0;
        end else begin
          res <= was_empty ? '0 : rd_data;
        end
      end
      ST_MUL: begin
        p_arcr <= a_re * c_re;
        p_aici <= a_im * c_im;
        p_brdr <= b_re * d_re;
        p_bidi <= b_im * d_im;
        p_arci <= a_re * c_im;
        p_aicr <= a_im * c_re;
        p_brdi <= b_re * d_im;
        p_bidr <= b_im * d_re;
      end
      ST_ADD: begin
        cur_re <= sat_re;
        cur_im <= sat_im;
      end
      ST_NORM: begin
        nrm <= 36'(cur_re * cur_re) + 36'(cur_im * cur_im);
      end
      ST_CHECK: begin
        if (nrm < tn) begin
          cur_re <= '0;
          cur_im <= '0;
        end
        rad  <= nrm;
        srem <= '0;
        root <= '0;
        cnt  <= '0;
      end
      ST_SQRT: begin
        // one root bit per cycle
        rad <= {rad[33:0], 2'b00};
        if (sq_t >= sq_trial) begin
          srem <= 20'(sq_t - sq_trial);
          root <= {root[16:0], 1'b1};
        end else begin
          srem <= sq_t[19:0];
          root <= {root[16:0], 1'b0};
        end
        if (cnt == 5'(SQRT_STEPS - 1)) begin
          cnt <= '0;
        end else begin
          cnt <= cnt + 5'd1;
        end
      end
      ST_DIV: begin
        if (cnt == 5'd0) begin
          // load numerators; quotient of 2^18 or more saturates
          drem_re <= {2'b00, num_re[34:18]};
          drem_im <= {2'b00, num_im[34:18]};
          dnum_re <= num_re[17:0];
          dnum_im <= num_im[17:0];
          ovf_re  <= {1'b0, num_re} >= {root, 18'd0};
          ovf_im  <= {1'b0, num_im} >= {root, 18'd0};
          q_re    <= '0;
          q_im    <= '0;
          cnt     <= 5'd1;
        end else if (cnt == 5'(DIV_STEPS + 1)) begin
          cnt <= '0;
        end else begin
          cnt <= cnt + 5'd1;
        end
        if (cnt != 5'd0 && cnt != 5'(DIV_STEPS + 1)) begin
          // one quotient bit per cycle per part
          dnum_re <= {dnum_re[16:0], 1'b0};
          dnum_im <= {dnum_im[16:0], 1'b0};
          if (d2_re >= {2'b00, root}) begin
            drem_re <= 19'(d2_re - {2'b00, root});
            q_re    <= {q_re[16:0], 1'b1};
          end else begin
            drem_re <= d2_re[18:0];
            q_re    <= {q_re[16:0], 1'b0};
          end
          if (d2_im >= {2'b00, root}) begin
            drem_im <= 19'(d2_im - {2'b00, root});
            q_im    <= {q_im[16:0], 1'b1};
          end else begin
            drem_im <= d2_im[18:0];
            q_im    <= {q_im[16:0], 1'b0};
          end
        end
        if (cnt == 5'(DIV_STEPS + 1)) begin
          cur_re <= fin_re;
          cur_im <= fin_im;
        end
      end
      ST_STORE: begin
        res.re[k] <= cur_re;
        res.im[k] <= cur_im;
        k <= k + 2'd1;
      end
      ST_IDNORM: begin
        n1 <= 36'(res.re[1] * res.re[1]) + 36'(res.im[1] * res.im[1]);
        n2 <= 36'(res.re[2] * res.re[2]) + 36'(res.im[2] * res.im[2]);
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Output register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata[QW-1:0] <= qubit;
      for (int i = 0; i < 4; i++) begin
        m_tdata[6 + 36*i +: 18]  <= res.re[i];
        m_tdata[24 + 36*i +: 18] <= res.im[i];
      end
      m_tdata[151:150] <= 2'b00;
      m_tuser[0] <= (was_empty && cmd == CMD_FLUSH) ? 1'b0 : ident;
      m_tuser[1] <= was_empty;
    end
  end

endmodule
